@@ sv/acg_pkg.sv @@
package acg_pkg;

	typedef enum logic [1:0] {
		REG_BYPASS    = 2'd0,
		REG_THRESHOLD = 2'd1,
		REG_INV_RATIO = 2'd2,
		REG_MAKEUP    = 2'd3
	} reg_idx_t;

	localparam logic [15:0] THRESHOLD_RST = 16'hEC00;
	localparam logic [15:0] INV_RATIO_RST = 16'd16384;
	localparam logic [13:0] MAKEUP_RST    = 14'd0;

	localparam logic [22:0] ATTACK_K    = 23'd4294967;
	localparam logic [22:0] RELEASE_K   = 23'd429497;
	localparam logic [31:0] ENV_FLOOR   = 32'd4295;
	localparam logic [18:0] DB_PER_LOG2 = 19'd394566;
	localparam logic [21:0] LOG2_PER_DB = 22'd2786635;

	// control settings; only the bypass bit travels with each queued item
	typedef struct packed {
		logic       bypass;
		logic [15:0] threshold;
		logic [15:0] inv_ratio;
		logic [13:0] makeup;
	} acg_cfg_t;

	function automatic logic [63:0] isqrt64(input logic [63:0] n);
		logic [63:0] rem;
		logic [63:0] res;
		logic [63:0] b;
		rem = n;
		res = 64'd0;
		b = 64'd1 << 62;
		for (int k = 0; k < 32; k++) begin
			if (b > rem) b = b >> 2;
		end
		for (int k = 0; k < 32; k++) begin
			if (b != 64'd0) begin
				if (rem >= res + b) begin
					rem = rem - (res + b);
					res = (res >> 1) + b;
				end else begin
					res = res >> 1;
				end
				b = b >> 2;
			end
		end
		return res;
	endfunction

	// 2^(2^-(k+1)) in Q1.30, each root taken from the one before
	function automatic logic [30:0] exp2_root(input int k);
		logic [63:0] r;
		r = isqrt64(64'd1 << 61);
		for (int j = 0; j < k; j++) begin
			r = isqrt64(r << 30);
		end
		return r[30:0];
	endfunction

	localparam logic [30:0] EXP2_ROOT [16] = '{
		exp2_root(0), exp2_root(1), exp2_root(2), exp2_root(3),
		exp2_root(4), exp2_root(5), exp2_root(6), exp2_root(7),
		exp2_root(8), exp2_root(9), exp2_root(10), exp2_root(11),
		exp2_root(12), exp2_root(13), exp2_root(14), exp2_root(15)
	};

endpackage

@@ sv/acg_front.sv @@
module acg_front #(
	parameter int SAMPLE_BITS = 24
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	output logic                   full,
	input  logic [SAMPLE_BITS-1:0] sample_in,
	input  logic                   bypass,
	output logic                   q_valid,
	input  logic                   q_take,
	output logic                   q_bypass,
	output logic [SAMPLE_BITS-1:0] q_sample
);

	logic [SAMPLE_BITS:0] mem_q [2];
	logic                 wr_ptr_q;
	logic                 rd_ptr_q;
	logic [1:0]           count_q;
	logic                 wr;
	logic                 rd;

	assign full     = (count_q == 2'd2);
	assign q_valid  = (count_q != 2'd0);
	assign wr       = push && !full;
	assign rd       = q_take && q_valid;
	assign q_bypass = mem_q[rd_ptr_q][SAMPLE_BITS];
	assign q_sample = mem_q[rd_ptr_q][SAMPLE_BITS-1:0];

	// tag each sample with its path at transfer time
	always_ff @(posedge clk) begin
		if (wr) mem_q[wr_ptr_q] <= {bypass, sample_in};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (wr) wr_ptr_q <= !wr_ptr_q;
			if (rd) rd_ptr_q <= !rd_ptr_q;
			if (wr && !rd) count_q <= count_q + 2'd1;
			else if (rd && !wr) count_q <= count_q - 2'd1;
		end
	end

endmodule

@@ sv/acg_back.sv @@
module acg_back #(
	parameter int SAMPLE_BITS = 24
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   q_valid,
	output logic                   q_take,
	input  logic                   q_bypass,
	input  logic [SAMPLE_BITS-1:0] q_sample,
	input  logic [15:0]            thresh_lvl,
	input  logic [15:0]            inverse_ratio,
	input  logic [13:0]            makeup_lvl,
	output logic                   empty,
	input  logic                   pop,
	output logic [SAMPLE_BITS-1:0] sample_out
);

	localparam int ASH = 33 - SAMPLE_BITS;
	localparam logic [63:0] MAXV = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;

	typedef enum logic [11:0] {
		S_IDLE  = 12'b000000000001,
		S_ENV   = 12'b000000000010,
		S_UPD   = 12'b000000000100,
		S_NORM  = 12'b000000001000,
		S_LOG   = 12'b000000010000,
		S_LVL   = 12'b000000100000,
		S_RED   = 12'b000001000000,
		S_GAIN  = 12'b000010000000,
		S_EXPI  = 12'b000100000000,
		S_EXP   = 12'b001000000000,
		S_SCALE = 12'b010000000000,
		S_OUT   = 12'b100000000000
	} st_t;

	st_t                    st_q;
	logic [SAMPLE_BITS-1:0] ax_q;
	logic                   xneg_q;
	logic [31:0]            env_q;
	logic                   up_q;
	logic [54:0]            eprod_q;
	logic [31:0]            m_q;
	logic [4:0]             p_q;
	logic [15:0]            frac_q;
	logic [3:0]             cnt_q;
	logic [40:0]            lvlp_q;
	logic [34:0]            redp_q;
	logic [41:0]            emp_q;
	logic                   gneg_q;
	logic [15:0]            f_q;
	logic signed [10:0]     ip_q;
	logic [31:0]            acc_q;
	logic [63:0]            sp_q;
	logic                   round_q;
	logic [SAMPLE_BITS-1:0] res_q;
	logic                   ov_q;
	logic [SAMPLE_BITS-1:0] out_q;

	logic [SAMPLE_BITS-1:0] ax_in;
	logic [32:0]            a_full;
	logic [31:0]            a32;
	logic                   up;
	logic [31:0]            ediff;
	logic [31:0]            env_n;
	logic [4:0]             lead;
	logic [63:0]            sq;
	logic [32:0]            mm;
	logic [21:0]            negv;
	logic signed [17:0]     lvl;
	logic signed [17:0]     thr;
	logic [16:0]            ldiff;
	logic [16:0]            irc;
	logic signed [19:0]     g;
	logic [18:0]            gabs;
	logic signed [26:0]     e;
	logic [62:0]            aprod;
	logic signed [11:0]     sh;
	logic [64:0]            rsum;
	logic [64:0]            mag;
	logic [SAMPLE_BITS-1:0] sat;
	logic                   out_free;

	assign ax_in  = q_sample[SAMPLE_BITS-1] ? (~q_sample + 1'b1) : q_sample;
	assign a_full = {ax_q, {ASH{1'b0}}};
	assign a32    = a_full[32] ? 32'hFFFF_FFFF : a_full[31:0];
	assign up     = a32 > env_q;
	assign ediff  = up ? (a32 - env_q) : (env_q - a32);

	always_comb begin
		env_n = up_q ? (env_q + {9'd0, eprod_q[54:32]}) : (env_q - {9'd0, eprod_q[54:32]});
		if (env_n < acg_pkg::ENV_FLOOR) env_n = acg_pkg::ENV_FLOOR;
	end

	always_comb begin
		lead = 5'd0;
		for (int i = 0; i < 32; i++) begin
			if (env_q[i]) lead = 5'(i);
		end
	end

	assign sq    = {32'd0, m_q} * {32'd0, m_q};
	assign mm    = sq[63:31];
	assign negv  = ({16'd0, 6'd32 - {1'b0, p_q}} << 16) - {6'd0, frac_q};
	assign lvl   = -$signed({1'b0, lvlp_q[40:24]});
	assign thr   = 18'(signed'(thresh_lvl));
	assign ldiff = 17'(lvl - thr);
	assign irc   = 17'd65536 - {1'b0, inverse_ratio};
	assign g     = 20'(signed'(makeup_lvl)) - $signed({1'b0, redp_q[34:16]});
	assign gabs  = g[19] ? 19'(-g) : g[18:0];
	assign e     = gneg_q ? -$signed({1'b0, emp_q[41:16]}) : $signed({1'b0, emp_q[41:16]});
	assign aprod = {31'd0, acc_q} * {32'd0, acg_pkg::EXP2_ROOT[cnt_q]};

	// rounding shift and saturation on the scaled magnitude
	assign sh   = 12'sd30 - 12'(ip_q);
	assign rsum = {1'b0, sp_q} + ((sh == 12'sd0) ? 65'd0 : (65'd1 << (sh - 12'sd1)));
	assign mag  = (sh > 12'sd63) ? 65'd0 : (rsum >> sh);

	always_comb begin
		if (!xneg_q && mag > {1'b0, MAXV}) sat = MAXV[SAMPLE_BITS-1:0];
		else if (xneg_q && mag > {1'b0, MAXV} + 65'd1) sat = ~MAXV[SAMPLE_BITS-1:0];
		else if (xneg_q) sat = ~mag[SAMPLE_BITS-1:0] + 1'b1;
		else sat = mag[SAMPLE_BITS-1:0];
	end

	assign q_take     = (st_q == S_IDLE);
	assign out_free   = !ov_q || pop;
	assign empty      = !ov_q;
	assign sample_out = out_q;

	always_ff @(posedge clk) begin
		case (st_q)
			S_IDLE: begin
				res_q  <= q_sample;
				ax_q   <= ax_in;
				xneg_q <= q_sample[SAMPLE_BITS-1];
			end
			S_ENV: begin
				up_q    <= up;
				eprod_q <= {23'd0, ediff} * {32'd0, (up ? acg_pkg::ATTACK_K : acg_pkg::RELEASE_K)};
			end
			S_NORM: begin
				p_q    <= lead;
				m_q    <= env_q << (5'd31 - lead);
				frac_q <= 16'd0;
			end
			S_LOG: begin
				// square, then renormalize and emit one fraction bit
				if (mm[32]) begin
					frac_q[4'd15 - cnt_q] <= 1'b1;
					m_q <= mm[32:1];
				end else begin
					m_q <= mm[31:0];
				end
			end
			S_LVL: lvlp_q <= {19'd0, negv} * {22'd0, acg_pkg::DB_PER_LOG2} + 41'd8388608;
			S_RED: begin
				if (lvl > thr) redp_q <= {18'd0, ldiff} * {18'd0, irc} + 35'd32768;
				else redp_q <= 35'd0;
			end
			S_GAIN: begin
				gneg_q <= g[19];
				emp_q  <= {23'd0, gabs} * {20'd0, acg_pkg::LOG2_PER_DB} + 42'd32768;
			end
			S_EXPI: begin
				f_q   <= e[15:0];
				ip_q  <= e[26:16];
				acc_q <= 32'd1 << 30;
			end
			S_EXP: if (f_q[4'd15 - cnt_q]) acc_q <= aprod[61:30];
			S_SCALE: begin
				if (!round_q) sp_q <= 64'(ax_q) * 64'(acc_q);
				else res_q <= sat;
			end
			default: ;
		endcase
		if (st_q == S_OUT && out_free) out_q <= res_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= S_IDLE;
			env_q   <= 32'd0;
			cnt_q   <= 4'd0;
			round_q <= 1'b0;
			ov_q    <= 1'b0;
		end else begin
			// load on a new result, drop on a transfer
			ov_q <= (st_q == S_OUT && out_free) || (ov_q && !pop);
			case (st_q)
				S_IDLE: if (q_valid) st_q <= q_bypass ? S_OUT : S_ENV;
				S_ENV:  st_q <= S_UPD;
				S_UPD: begin
					env_q <= env_n;
					st_q  <= S_NORM;
				end
				S_NORM: begin
					cnt_q <= 4'd0;
					st_q  <= S_LOG;
				end
				S_LOG: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'd15) st_q <= S_LVL;
				end
				S_LVL:  st_q <= S_RED;
				S_RED:  st_q <= S_GAIN;
				S_GAIN: st_q <= S_EXPI;
				S_EXPI: begin
					cnt_q <= 4'd0;
					st_q  <= S_EXP;
				end
				S_EXP: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'd15) st_q <= S_SCALE;
				end
				S_SCALE: begin
					// first pass multiplies, second pass rounds
					round_q <= !round_q;
					if (round_q) st_q <= S_OUT;
				end
				S_OUT: begin
					if (out_free) st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	a_env_floor: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_NORM) |-> (env_q >= acg_pkg::ENV_FLOOR))
		else $error("envelope below floor");

	a_log_norm: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_LOG) |-> m_q[31])
		else $error("log mantissa not normalized");

	a_exp_range: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_SCALE) |-> (acc_q >= (32'd1 << 30) && acc_q <= (32'd1 << 31)))
		else $error("exp2 factor out of range");

	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_OUT && ov_q && !pop) |=> (st_q == S_OUT))
		else $error("result left while output register full");

endmodule

@@ sv/audio_compressor_envelope_gain_core.sv @@
// Mono feed-forward compressor, one signed Q1.(SAMPLE_BITS-1) sample per item.
// Input side is a queue: drive sample_in and push; the transfer happens when
// push is high and full is low. A two-entry queue holds samples while the
// gain engine is busy. Result side is a queue: sample_out is valid while
// empty is low and is taken at an edge with pop high.
// Configuration: wr_en, wr_index, wr_data write bypass, threshold,
// inverse_ratio and make-up gain; write only while no sample is in flight.
// Processing: a compressed sample passes from the queue head to the output register
// through an envelope update, 16 log2 squarings, 16 exp2 root multiplies, a scale
// and a rounding step on one shared sequencer; the next sample is taken from the
// queue only once the sequencer is back in idle. A bypassed sample goes from idle
// straight to the output step.
// When pop is held low the finished result stays in the output register; the
// engine holds its next result and the input queue fills, then full rises.
// Reset clears the envelope, the queues and the registers to their defaults.
module audio_compressor_envelope_gain_core #(
	parameter int SAMPLE_BITS = 24
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	output logic                   full,
	input  logic [SAMPLE_BITS-1:0] sample_in,
	output logic                   empty,
	input  logic                   pop,
	output logic [SAMPLE_BITS-1:0] sample_out,
	input  logic                   wr_en,
	input  logic [1:0]             wr_index,
	input  logic [15:0]            wr_data
);

	acg_pkg::acg_cfg_t      cfg_q;
	logic                   q_valid;
	logic                   q_take;
	logic                   q_bypass;
	logic [SAMPLE_BITS-1:0] q_sample;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bypass    <= 1'b0;
			cfg_q.threshold <= acg_pkg::THRESHOLD_RST;
			cfg_q.inv_ratio <= acg_pkg::INV_RATIO_RST;
			cfg_q.makeup    <= acg_pkg::MAKEUP_RST;
		end else if (wr_en) begin
			case (acg_pkg::reg_idx_t'(wr_index))
				acg_pkg::REG_BYPASS:    cfg_q.bypass    <= wr_data[0];
				acg_pkg::REG_THRESHOLD: cfg_q.threshold <= wr_data;
				acg_pkg::REG_INV_RATIO: cfg_q.inv_ratio <= wr_data;
				acg_pkg::REG_MAKEUP:    cfg_q.makeup    <= wr_data[13:0];
				default: ;
			endcase
		end
	end

	acg_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.sample_in(sample_in),
		.bypass   (cfg_q.bypass),
		.q_valid  (q_valid),
		.q_take   (q_take),
		.q_bypass (q_bypass),
		.q_sample (q_sample)
	);

	acg_back #(.SAMPLE_BITS(SAMPLE_BITS)) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_valid),
		.q_take        (q_take),
		.q_bypass      (q_bypass),
		.q_sample      (q_sample),
		.thresh_lvl    (cfg_q.threshold),
		.inverse_ratio (cfg_q.inv_ratio),
		.makeup_lvl    (cfg_q.makeup),
		.empty         (empty),
		.pop           (pop),
		.sample_out    (sample_out)
	);

endmodule
